@@ sv/macs_pkg.sv @@
`timescale 1ns / 1ps

package macs_pkg;

    // history depth
    localparam int MAX_WINDOW_DEF = 256;

    // field widths
    localparam int PRICE_W      = 32;
    localparam int WORTH_W      = 32;
    localparam int ALLOC_W      = 33;
    localparam int WINDOW_REG_W = 9;
    localparam int PCT_W        = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 9;

    // register reset values
    localparam logic [WINDOW_REG_W-1:0] SHORT_WINDOW_RST = 9'd1;
    localparam logic [WINDOW_REG_W-1:0] LONG_WINDOW_RST  = 9'd2;
    localparam logic [PCT_W-1:0]        RESERVE_RST      = 7'd0;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // divide by one hundred split over the two halves of net worth
    localparam int HALF_W      = 16;
    localparam int PART_W      = 23;
    localparam int MID_W       = 24;
    localparam int LOW_QUOT_W  = 17;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_PROD_W = MID_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_WINDOW = 2'd0,
        REG_LONG_WINDOW  = 2'd1,
        REG_RESERVE      = 2'd2
    } macs_reg_t;

    // accept, clear, step and load enables handed from the top level to the datapath units
    typedef struct packed {
        logic accept;
        logic clear;
        logic step;
        logic ld2;
        logic ld3;
        logic ld4;
    } macs_ctrl_t;

endpackage

@@ sv/macs_if.sv @@
`timescale 1ns / 1ps

interface macs_sample_if;
    import macs_pkg::*;
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic [WORTH_W-1:0] net_worth;

    modport source (output valid, output price, output net_worth, input ready);
    modport sink   (input valid, input price, input net_worth, output ready);
endinterface

interface macs_result_if;
    import macs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ALLOC_W-1:0] allocation;
    logic                      warm;
    logic                      settings_ok;

    modport source (output valid, output allocation, output warm, output settings_ok,
                    input ready);
    modport sink   (input valid, input allocation, input warm, input settings_ok,
                    output ready);
endinterface

interface macs_cfg_if;
    import macs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/moving_average_crossover_signal.sv @@
`timescale 1ns / 1ps

// channel   dir   handshake      payload
// cfg       in    valid/ready    index, data (short, long window, reserve)
// sample    in    valid/ready    price, net_worth
// result    out   valid/ready    allocation, warm, settings_ok
//
// one item per cycle while result is ready; a taken item passes every stage register
// the stages follow the divide-by-hundred chain and the registered history read
// reset clears window sums, history pointer, fill count; config takes reset values
// a stall on result backs up stage by stage, so free stages still take items
// cfg is always ready; a window write restarts the history, a reserve write does not

module moving_average_crossover_signal #(
    parameter int MAX_WINDOW = macs_pkg::MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    macs_cfg_if.sink          cfg,
    macs_sample_if.sink       sample,
    macs_result_if.source     result
);
    import macs_pkg::*;

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);

    // config registers
    logic [WINDOW_REG_W-1:0] short_window_reg;
    logic [WINDOW_REG_W-1:0] long_window_reg;
    logic [PCT_W-1:0]        reserve_reg;

    logic [WIN_W-1:0] short_len, long_len;

    // stage occupancy and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic accept, clear;
    macs_ctrl_t ctrl;

    // datapath hand-offs
    logic [PRICE_W-1:0] leave_short, leave_long;
    logic               warm1, warm2_reg, warm3_reg, warm4_reg;
    logic               above;
    logic [WORTH_W-1:0] magnitude;

    // result register
    logic signed [ALLOC_W-1:0] allocation_reg, allocation_next;
    logic                      warm_out_reg, ok_reg, ok_next;

    // a window of zero acts as one, above the history depth as the depth
    function automatic logic [WIN_W-1:0] eff_len(input logic [WINDOW_REG_W-1:0] w);
        if (w == '0)
        begin
            return WIN_W'(1);
        end
        else if (int'(w) > MAX_WINDOW)
        begin
            return WIN_W'(MAX_WINDOW);
        end
        else
        begin
            return WIN_W'(w);
        end
    endfunction

    assign short_len = eff_len(short_window_reg);
    assign long_len  = eff_len(long_window_reg);

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign clear     = cfg.valid
                       && ((cfg.index == REG_SHORT_WINDOW) || (cfg.index == REG_LONG_WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg <= SHORT_WINDOW_RST;
            long_window_reg  <= LONG_WINDOW_RST;
            reserve_reg      <= RESERVE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SHORT_WINDOW: short_window_reg <= cfg.data[WINDOW_REG_W-1:0];
                REG_LONG_WINDOW:  long_window_reg  <= cfg.data[WINDOW_REG_W-1:0];
                REG_RESERVE:      reserve_reg      <= cfg.data[PCT_W-1:0];
                default:          ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow: a stage loads when empty or when its item moves on
    // ---------------------------------------------------------------
    assign ld_out = !out_valid_reg || result.ready;
    assign ld4    = !v4_reg || ld_out;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;

    assign sample.ready = ld1;
    assign accept       = sample.valid && ld1;

    assign ctrl.accept = accept;
    assign ctrl.clear  = clear;
    assign ctrl.step   = ld2 && v1_reg;   // sums move only with a real item
    assign ctrl.ld2    = ld2;
    assign ctrl.ld3    = ld3;
    assign ctrl.ld4    = ld4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= sample.valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath units
    // ---------------------------------------------------------------
    macs_history #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .price       (sample.price),
        .short_len   (short_len),
        .long_len    (long_len),
        .leave_short (leave_short),
        .leave_long  (leave_long),
        .warm        (warm1)
    );

    macs_trend #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_trend (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .price       (sample.price),
        .leave_short (leave_short),
        .leave_long  (leave_long),
        .short_len   (short_len),
        .long_len    (long_len),
        .above       (above)
    );

    macs_sizer u_sizer (
        .clk       (clk),
        .ctrl      (ctrl),
        .net_worth (sample.net_worth),
        .reserve   (reserve_reg),
        .magnitude (magnitude)
    );

    // warm flag rides along with its item
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            warm2_reg <= warm1;
        end
        if (ld3)
        begin
            warm3_reg <= warm2_reg;
        end
        if (ld4)
        begin
            warm4_reg <= warm3_reg;
        end
    end

    // ---------------------------------------------------------------
    // result register: sign from the crossover, equal averages go short
    // ---------------------------------------------------------------
    assign allocation_next = above ? $signed({1'b0, magnitude}) : -$signed({1'b0, magnitude});
    assign ok_next         = (short_window_reg < long_window_reg) && (reserve_reg <= PCT_FULL);

    always_ff @(posedge clk)
    begin
        if (ld_out && v4_reg)
        begin
            allocation_reg <= allocation_next;
            warm_out_reg   <= warm4_reg;
            ok_reg         <= ok_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.allocation  = allocation_reg;
    assign result.warm        = warm_out_reg;
    assign result.settings_ok = ok_reg;

endmodule

@@ sv/macs_history.sv @@
`timescale 1ns / 1ps

module macs_history #(
    parameter int MAX_WINDOW = macs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  macs_pkg::macs_ctrl_t                   ctrl,
    input  logic [macs_pkg::PRICE_W-1:0]           price,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]        short_len,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]        long_len,
    output logic [macs_pkg::PRICE_W-1:0]           leave_short,
    output logic [macs_pkg::PRICE_W-1:0]           leave_long,
    output logic                                   warm
);
    import macs_pkg::*;

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int ADR_W = WIN_W + 1;
    localparam logic [ADR_W-1:0] DEPTH = ADR_W'(MAX_WINDOW);

    logic [PRICE_W-1:0] mem [MAX_WINDOW];

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [WIN_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]   addr_short, addr_long;
    logic [PRICE_W-1:0] rd_short_reg, rd_long_reg;
    logic               hit_short_reg, hit_long_reg, warm_reg;

    // slot that was written len samples ago, modulo the depth
    function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] ptr,
                                                   input logic [WIN_W-1:0] len);
        logic [ADR_W-1:0] t;
        t = ADR_W'(ptr) + DEPTH - ADR_W'(len);
        if (t >= DEPTH)
        begin
            t = t - DEPTH;
        end
        return t[PTR_W-1:0];
    endfunction

    assign addr_short  = back_addr(wr_ptr_reg, short_len);
    assign addr_long   = back_addr(wr_ptr_reg, long_len);
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
    assign fill_next   = (fill_reg == WIN_W'(MAX_WINDOW)) ? fill_reg : fill_reg + WIN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (ctrl.clear)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (ctrl.accept)
        begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // read before write: a window of full depth sees the old slot
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            mem[wr_ptr_reg] <= price;
            rd_short_reg    <= mem[addr_short];
            rd_long_reg     <= mem[addr_long];
            hit_short_reg   <= (fill_reg >= short_len);
            hit_long_reg    <= (fill_reg >= long_len);
            warm_reg        <= (fill_next >= long_len);
        end
    end

    // slots not written since the last clear count as zero
    assign leave_short = hit_short_reg ? rd_short_reg : '0;
    assign leave_long  = hit_long_reg  ? rd_long_reg  : '0;
    assign warm        = warm_reg;

endmodule

@@ sv/macs_trend.sv @@
`timescale 1ns / 1ps

module macs_trend #(
    parameter int MAX_WINDOW = macs_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  macs_pkg::macs_ctrl_t              ctrl,
    input  logic [macs_pkg::PRICE_W-1:0]      price,
    input  logic [macs_pkg::PRICE_W-1:0]      leave_short,
    input  logic [macs_pkg::PRICE_W-1:0]      leave_long,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   short_len,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   long_len,
    output logic                              above
);
    import macs_pkg::*;

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
    localparam int PROD_W = SUM_W + WIN_W;

    logic [PRICE_W-1:0] price_reg;
    logic [SUM_W-1:0]   short_sum_reg, short_sum_next;
    logic [SUM_W-1:0]   long_sum_reg, long_sum_next;
    logic [PROD_W-1:0]  cross_short_reg, cross_long_reg;
    logic               above_reg;

    assign short_sum_next = short_sum_reg + SUM_W'(price_reg) - SUM_W'(leave_short);
    assign long_sum_next  = long_sum_reg  + SUM_W'(price_reg) - SUM_W'(leave_long);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            price_reg <= price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
        end
    end

    // averages compared by cross multiplication
    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            cross_short_reg <= PROD_W'(short_sum_reg) * PROD_W'(long_len);
            cross_long_reg  <= PROD_W'(long_sum_reg) * PROD_W'(short_len);
        end
        if (ctrl.ld4)
        begin
            above_reg <= (cross_short_reg > cross_long_reg);
        end
    end

    assign above = above_reg;

endmodule

@@ sv/macs_sizer.sv @@
`timescale 1ns / 1ps

module macs_sizer (
    input  logic                         clk,
    input  macs_pkg::macs_ctrl_t         ctrl,
    input  logic [macs_pkg::WORTH_W-1:0] net_worth,
    input  logic [macs_pkg::PCT_W-1:0]   reserve,
    output logic [macs_pkg::WORTH_W-1:0] magnitude
);
    import macs_pkg::*;

    logic [PCT_W-1:0]        keep;
    logic [PART_W-1:0]       hi1_reg, lo1_reg, hi2_reg, lo2_reg;
    logic [HALF_W-1:0]       qh2_reg, qh3_reg, qh4_reg;
    logic [RECIP_PROD_W-1:0] hi_prod, mid_prod;
    logic [PART_W-1:0]       hi_back;
    logic [PCT_W-1:0]        hi_rem;
    logic [MID_W-1:0]        mid_reg;
    logic [LOW_QUOT_W-1:0]   ql_reg;
    logic [WORTH_W:0]        total;

    assign keep = PCT_FULL - ((reserve > PCT_FULL) ? PCT_FULL : reserve);

    // upper half quotient, then remainder carried into the lower half
    assign hi_prod  = RECIP_PROD_W'(hi1_reg) * RECIP_PROD_W'(RECIP_100);
    assign hi_back  = PART_W'(qh2_reg) * PART_W'(PCT_FULL);
    assign hi_rem   = PCT_W'(hi2_reg - hi_back);
    assign mid_prod = RECIP_PROD_W'(mid_reg) * RECIP_PROD_W'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            hi1_reg <= PART_W'(net_worth[WORTH_W-1:HALF_W]) * PART_W'(keep);
            lo1_reg <= PART_W'(net_worth[HALF_W-1:0]) * PART_W'(keep);
        end
        if (ctrl.ld2)
        begin
            qh2_reg <= hi_prod[RECIP_SHIFT +: HALF_W];
            hi2_reg <= hi1_reg;
            lo2_reg <= lo1_reg;
        end
        if (ctrl.ld3)
        begin
            mid_reg <= (MID_W'(hi_rem) << HALF_W) + MID_W'(lo2_reg);
            qh3_reg <= qh2_reg;
        end
        if (ctrl.ld4)
        begin
            ql_reg  <= mid_prod[RECIP_SHIFT +: LOW_QUOT_W];
            qh4_reg <= qh3_reg;
        end
    end

    assign total     = {1'b0, qh4_reg, {HALF_W{1'b0}}} + (WORTH_W + 1)'(ql_reg);
    assign magnitude = total[WORTH_W-1:0];

endmodule

@@ sv/macs_checker.sv @@
`timescale 1ns / 1ps

module macs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [macs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [macs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [macs_pkg::ALLOC_W-1:0] allocation,
    input logic                             warm,
    input logic                             settings_ok
);
    import macs_pkg::*;

    logic [WINDOW_REG_W-1:0] short_window_reg;
    logic [WINDOW_REG_W-1:0] long_window_reg;
    logic [PCT_W-1:0]        reserve_reg;
    logic [7:0]              pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg <= SHORT_WINDOW_RST;
            long_window_reg  <= LONG_WINDOW_RST;
            reserve_reg      <= RESERVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHORT_WINDOW: short_window_reg <= cfg_data[WINDOW_REG_W-1:0];
                REG_LONG_WINDOW:  long_window_reg  <= cfg_data[WINDOW_REG_W-1:0];
                REG_RESERVE:      reserve_reg      <= cfg_data[PCT_W-1:0];
                default:          ;
            endcase
        end
    end

    // items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(allocation) && $stable(warm)
                                    && $stable(settings_ok))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result with no item outstanding");

    a_settings_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> settings_ok == ((short_window_reg < long_window_reg)
                                      && (reserve_reg <= PCT_FULL)))
        else $error("settings_ok disagrees with written registers");

    a_full_reserve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reserve_reg >= PCT_FULL) |-> allocation == '0)
        else $error("allocation not zero with full reserve");

endmodule

bind moving_average_crossover_signal macs_checker u_macs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .allocation  (result.allocation),
    .warm        (result.warm),
    .settings_ok (result.settings_ok)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import macs_pkg::*;

    // index with no register behind it, the block must ignore a write to it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // one sample item as offered on the sample channel
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [WORTH_W-1:0] net_worth;
    } quote_t;

    // one result item as it should leave the block
    typedef struct packed {
        logic signed [ALLOC_W-1:0] allocation;
        logic                      warm;
        logic                      settings_ok;
    } signal_t;

    logic clk;
    logic rst_n;

    macs_cfg_if    cfg_ch ();
    macs_sample_if sample_ch ();
    macs_result_if result_ch ();

    moving_average_crossover_signal uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    // ---------------------------------------------------------------
    // crossover predictor: own copy of history, sums and registers
    // ---------------------------------------------------------------
    logic [PRICE_W-1:0]      hist_mem [MAX_WINDOW_DEF];
    logic [63:0]             sum_short;
    logic [63:0]             sum_long;
    logic [7:0]              slot_ptr;
    logic [8:0]              fill_count;
    logic [WINDOW_REG_W-1:0] cfg_short = SHORT_WINDOW_RST;
    logic [WINDOW_REG_W-1:0] cfg_long  = LONG_WINDOW_RST;
    logic [PCT_W-1:0]        cfg_reserve = RESERVE_RST;

    quote_t  quote_q [$];   // items waiting for the sample driver
    signal_t signal_q [$];  // signals predicted but not yet seen

    int  mismatch_count = 0;
    int  samples_taken = 0;
    int  signals_checked = 0;
    int  settings_used = 0;
    bit  send_calm = 0;     // sender offers back to back
    bit  recv_calm = 0;     // receiver never stalls
    logic s_fire = 0;
    logic r_fire = 0;

    // price walk used by the random part
    logic [PRICE_W-1:0] walk_price;
    int                 trend_step;
    int                 trend_left = 0;

    function automatic void wipe_history();
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
            hist_mem[i] = '0;
        sum_short  = '0;
        sum_long   = '0;
        slot_ptr   = '0;
        fill_count = '0;
    endfunction

    // a window of zero acts as one, anything past the history depth as the depth
    function automatic logic [8:0] clamp_window(input logic [WINDOW_REG_W-1:0] w);
        if (w == 0)
            return 9'd1;
        if (w > MAX_WINDOW_DEF)
            return 9'(MAX_WINDOW_DEF);
        return w;
    endfunction

    function automatic signal_t crossover_step(input logic [PRICE_W-1:0] price,
                                               input logic [WORTH_W-1:0] worth);
        signal_t            sig;
        logic [8:0]         s_w;
        logic [8:0]         l_w;
        logic [PRICE_W-1:0] leave_s;
        logic [PRICE_W-1:0] leave_l;
        logic [PCT_W-1:0]   pct;
        logic [63:0]        amount;
        logic               above;
        s_w = clamp_window(cfg_short);
        l_w = clamp_window(cfg_long);
        // oldest samples of each window, read before the new one lands
        leave_s = hist_mem[8'(slot_ptr - s_w[7:0])];
        leave_l = hist_mem[8'(slot_ptr - l_w[7:0])];
        hist_mem[slot_ptr] = price;
        sum_short = sum_short + price - leave_s;
        sum_long  = sum_long + price - leave_l;
        slot_ptr  = slot_ptr + 8'd1;
        if (fill_count < MAX_WINDOW_DEF)
            fill_count = fill_count + 9'd1;
        // averages compared by cross-multiplication, ties go short
        above = (sum_short * 64'(l_w)) > (sum_long * 64'(s_w));
        pct = (cfg_reserve > PCT_FULL) ? PCT_FULL : cfg_reserve;
        amount = (64'(worth) * 64'(PCT_FULL - pct)) / 64'(PCT_FULL);
        sig.allocation  = above ? amount[ALLOC_W-1:0] : ALLOC_W'(-amount);
        sig.warm        = (fill_count >= l_w);
        sig.settings_ok = (cfg_short < cfg_long) && (cfg_reserve <= PCT_FULL);
        return sig;
    endfunction

    // ---------------------------------------------------------------
    // clock, and everything driven to a known value from time zero
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.price = '0;
        sample_ch.net_worth = '0;
        result_ch.ready = 1'b1;
    end

    // ---------------------------------------------------------------
    // monitor: handshakes are taken at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        signal_t got;
        signal_t want;
        if (!rst_n)
        begin
            s_fire <= 1'b0;
            r_fire <= 1'b0;
        end
        else
        begin
            s_fire <= sample_ch.valid && sample_ch.ready;
            r_fire <= result_ch.valid && result_ch.ready;
            // predict first, so a result taken in the same cycle as its item would still line up
            if (sample_ch.valid && sample_ch.ready)
            begin
                signal_q.push_back(crossover_step(sample_ch.price, sample_ch.net_worth));
                samples_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.allocation  = result_ch.allocation;
                got.warm        = result_ch.warm;
                got.settings_ok = result_ch.settings_ok;
                if (signal_q.size() == 0)
                begin
                    $display("%0t: result item with nothing expected, allocation %0d",
                             $time, got.allocation);
                    mismatch_count++;
                end
                else
                begin
                    want = signal_q.pop_front();
                    signals_checked++;
                    if (got.allocation !== want.allocation)
                    begin
                        $display("%0t: allocation expected %0d, got %0d",
                                 $time, want.allocation, got.allocation);
                        mismatch_count++;
                    end
                    if (got.warm !== want.warm)
                    begin
                        $display("%0t: warm expected %0b, got %0b",
                                 $time, want.warm, got.warm);
                        mismatch_count++;
                    end
                    if (got.settings_ok !== want.settings_ok)
                    begin
                        $display("%0t: settings_ok expected %0b, got %0b",
                                 $time, want.settings_ok, got.settings_ok);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sample driver: changes at the falling edge, unless send_calm a random gap per item
    // ---------------------------------------------------------------
    int send_wait = -1;

    always @(negedge clk)
    begin : drive_samples
        quote_t q;
        logic   offer;
        if (rst_n && !(sample_ch.valid && !s_fire))
        begin
            offer = 1'b0;
            if (quote_q.size() != 0)
            begin
                if (send_wait < 0)
                    send_wait = send_calm ? 0 : $urandom_range(0, 9);
                if (send_wait == 0)
                begin
                    q = quote_q.pop_front();
                    sample_ch.price <= q.price;
                    sample_ch.net_worth <= q.net_worth;
                    offer = 1'b1;
                    send_wait = -1;
                end
                else
                    send_wait--;
            end
            sample_ch.valid <= offer;
        end
    end

    // ---------------------------------------------------------------
    // result receiver: unless recv_calm, random stall after each item taken
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (r_fire && !recv_calm)
                stall_left = $urandom_range(0, 9);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_quote(input logic [PRICE_W-1:0] p, input logic [WORTH_W-1:0] w);
        quote_t q;
        q.price = p;
        q.net_worth = w;
        quote_q.push_back(q);
    endtask

    // wait until the block holds nothing, then let the pipeline empty out
    task automatic settle();
        while (quote_q.size() != 0 || sample_ch.valid || signal_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one register write; the predictor follows at the same edge
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_SHORT_WINDOW:
            begin
                cfg_short = val;
                wipe_history();
            end
            REG_LONG_WINDOW:
            begin
                cfg_long = val;
                wipe_history();
            end
            REG_RESERVE:
                cfg_reserve = val[PCT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        // back on a rising edge so queue pushes never meet the driver
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [8:0] s, input logic [8:0] l,
                               input logic [8:0] r);
        settle();
        cfg_write(REG_SHORT_WINDOW, s);
        cfg_write(REG_LONG_WINDOW, l);
        cfg_write(REG_RESERVE, r);
        settings_used++;
    endtask

    // trending walk with the odd jump and the odd extreme
    function logic [PRICE_W-1:0] next_price();
        int jitter;
        if ($urandom_range(0, 15) == 0)
            walk_price = $urandom;
        else if ($urandom_range(0, 31) == 0)
            walk_price = $urandom_range(0, 1) ? '1 : '0;
        if (trend_left == 0)
        begin
            trend_left = $urandom_range(4, 40);
            trend_step = int'($urandom_range(0, 2097152)) - 1048576;
        end
        trend_left--;
        jitter = int'($urandom_range(0, 4095)) - 2048;
        walk_price = walk_price + PRICE_W'(trend_step) + PRICE_W'(jitter);
        return walk_price;
    endfunction

    function automatic logic [WORTH_W-1:0] next_worth();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0] pick_extreme_window();
        case ($urandom_range(0, 4))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd255;
            3: return 9'd256;
            default: return 9'd511;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin : run_sequence
        logic [8:0] s;
        logic [8:0] l;
        logic [8:0] r;
        int         n;
        wipe_history();
        walk_price = $urandom;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings_used = 1;

        // reset settings, short 1 long 2: field extremes and a tie
        push_quote('0, '0);
        push_quote('1, '1);
        push_quote('0, '1);
        push_quote('1, 32'd1);
        push_quote('1, '1);
        push_quote(32'd100, 32'd12345);
        settle();

        // full reserve: allocation zero whichever way the sign goes
        reconfigure(9'd3, 9'd5, 9'd100);
        for (int i = 0; i < 4; i++)
            push_quote(32'h0001_0000 * (i + 1), '1);
        push_quote('0, '1);

        // zero windows act as one, reserve past a hundred clamps, not ok
        reconfigure(9'd0, 9'd0, 9'd127);
        push_quote(32'h0005_0000, '1);
        push_quote(32'h0009_0000, 32'h8000_0000);
        push_quote(32'h0001_0000, 32'h0000_ffff);

        // oversized windows act as the full depth, so averages always tie
        reconfigure(9'd300, 9'd511, 9'd37);
        push_quote('1, '1);
        push_quote(32'd7, 32'h1234_5678);
        push_quote('0, '1);

        // a write to the spare index changes nothing
        settle();
        cfg_write(REG_SPARE, 9'h1ff);
        push_quote(32'h0002_0000, 32'h0064_0000);

        reconfigure(9'd1, 9'd256, 9'd1);
        push_quote('1, '1);
        push_quote(32'd0, 32'd99);
        push_quote(32'd5, 32'd100);

        reconfigure(9'd255, 9'd256, 9'd0);
        push_quote('1, '1);
        push_quote(32'h0003_0000, 32'h0000_0001);
        settle();

        // random settings, most windows short, a few at the full depth
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 7))
                5:
                begin
                    l = 9'($urandom_range(200, 256));
                    s = 9'($urandom_range(1, l - 1));
                    r = 9'($urandom_range(0, 100));
                end
                6:
                begin
                    s = 9'($urandom);
                    l = 9'($urandom);
                    r = 9'($urandom_range(0, 127));
                end
                7:
                begin
                    s = pick_extreme_window();
                    l = pick_extreme_window();
                    r = $urandom_range(0, 1) ? 9'd127 : 9'(PCT_FULL);
                end
                default:
                begin
                    l = 9'($urandom_range(2, 40));
                    s = 9'($urandom_range(1, l - 1));
                    r = 9'($urandom_range(0, 100));
                end
            endcase
            reconfigure(s, l, r);
            send_calm = (ph % 3 == 1);
            recv_calm = (ph % 3 == 2);
            n = (clamp_window(l) > 64) ? 260 : 120;
            for (int i = 0; i < n; i++)
            begin
                // halfway through some phases: reserve alone, history kept
                if (ph % 2 == 1 && i == n / 2)
                begin
                    settle();
                    cfg_write(REG_RESERVE, 9'($urandom_range(0, 127)));
                    settings_used++;
                end
                push_quote(next_price(), next_worth());
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d sample items under %0d register settings", samples_taken,
                 settings_used);
        $display("%0d result items compared, %0d mismatches", signals_checked,
                 mismatch_count);
        if (mismatch_count == 0 && signal_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("timeout with %0d result items outstanding", signal_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

@@ moving_average_crossover_signal.f @@
sv/macs_pkg.sv
sv/macs_if.sv
sv/macs_history.sv
sv/macs_trend.sv
sv/macs_sizer.sv
sv/moving_average_crossover_signal.sv
sv/macs_checker.sv
bench/tb_top.sv
